// ----- rtl/ptc_pkg.sv -----
package ptc_pkg;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] temperature;
    logic [31:0]        pressure;
    logic               divide_by_zero;
  } out_beat_t;

  localparam logic [1:0] REG_TEMP    = 2'd0;
  localparam logic [1:0] REG_PRESS_A = 2'd1;
  localparam logic [1:0] REG_PRESS_B = 2'd2;
  localparam logic [1:0] REG_PRESS_C = 2'd3;

  localparam int DivW  = 64;

  // Calibration set as seen by the datapath
  typedef struct packed {
    logic [47:0] tc;
    logic [47:0] pa;
    logic [47:0] pb;
    logic [47:0] pc;
  } coeffs_t;

  function automatic logic [63:0] sx16(input logic [15:0] v);
    sx16 = {{48{v[15]}}, v};
  endfunction

endpackage

// ----- rtl/ptc_divider.sv -----
// Pipelined signed 64-bit divider, one quotient bit per stage, truncating.
// Carries a sideband word alongside each beat.
module ptc_divider #(
  parameter int SideW = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [63:0]             num,
  input  logic [63:0]             den,
  input  logic [SideW-1:0]        side_in,
  output logic                    out_valid,
  output logic [63:0]             quo,
  output logic [SideW-1:0]        side_out
);
  localparam int N = ptc_pkg::DivW;

  logic [N:0]       vld;
  logic [63:0]      rem [N+1];
  logic [63:0]      qq  [N+1];
  logic [63:0]      dv  [N+1];
  logic             neg [N+1];
  logic [SideW-1:0] sd  [N+1];

  // stage 0: take magnitudes
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= 64'd0;
      qq[0]  <= num[63] ? (64'd0 - num) : num;
      dv[0]  <= den[63] ? (64'd0 - den) : den;
      neg[0] <= num[63] ^ den[63];
      sd[0]  <= side_in;
    end
  end

  // restoring steps, MSB first; qq shifts out dividend bits, in quotient bits
  for (genvar i = 0; i < N; i++) begin : g_step
    logic [64:0] trial;
    logic [64:0] diff;
    assign trial = {rem[i], qq[i][63]};
    assign diff  = trial - {1'b0, dv[i]};
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= diff[64] ? trial[63:0] : diff[63:0];
        qq[i+1]  <= {qq[i][62:0], ~diff[64]};
        dv[i+1]  <= dv[i];
        neg[i+1] <= neg[i];
        sd[i+1]  <= sd[i];
      end
    end
  end

  assign out_valid = vld[N];
  assign quo       = neg[N] ? (64'd0 - qq[N]) : qq[N];
  assign side_out  = sd[N];
endmodule

// ----- rtl/ptc_front.sv -----
// Front stages: temperature and the pressure numerator/denominator.
// Seven register stages, one multiply per stage path.
module ptc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  ptc_pkg::in_beat_t in_beat,
  input  ptc_pkg::coeffs_t  cf,
  output logic              out_valid,
  output logic [31:0]       temp,
  output logic [63:0]       num,
  output logic [63:0]       den
);
  logic [6:0] vld;

  // stage 1
  logic [31:0] s1_x, s1_d, s1_t2, s1_t3;
  logic [19:0] s1_p;
  // stage 2
  logic [31:0] s2_a, s2_dd, s2_t3;
  logic [19:0] s2_p;
  // stage 3
  logic [31:0] s3_a, s3_b;
  logic [19:0] s3_p;
  // stage 4
  logic [31:0] s4_fine;
  logic [32:0] s4_v1;
  logic [19:0] s4_p;
  // stage 5
  logic [31:0] s5_fine;
  logic [63:0] s5_sq, s5_v1p5, s5_v1p2;
  logic [19:0] s5_p;
  // stage 6
  logic [31:0] s6_temp;
  logic [63:0] s6_v2, s6_v1a, s6_n0;
  logic [19:0] s6_p;
  // stage 7 (outputs)
  logic [31:0] s7_temp;
  logic [63:0] s7_num, s7_den;

  logic [31:0] t1;
  logic [31:0] adc_t;
  assign t1    = {16'd0, cf.tc[15:0]};
  assign adc_t = {12'd0, in_beat.raw_temperature};

  // fine temperature; v1 always fits 33 signed bits
  logic [31:0] s3_fine;
  assign s3_fine = s3_a + s3_b;

  logic [31:0] fine5;
  logic [63:0] p1, s5_sq3, s5_sq6;
  assign fine5  = s5_fine * 32'd5 + 32'd128;
  assign p1     = {48'd0, cf.pa[15:0]};
  assign s5_sq3 = s5_sq * 64'($signed(cf.pa[47:32]));
  assign s5_sq6 = s5_sq * 64'($signed(cf.pb[47:32]));

  logic [63:0] v1b;
  assign v1b = $signed(s6_v1a) >>> 8;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[5:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: differences
      s1_x  <= (adc_t >> 3) - (t1 << 1);
      s1_d  <= (adc_t >> 4) - t1;
      s1_t2 <= {{16{cf.tc[31]}}, cf.tc[31:16]};
      s1_t3 <= {{16{cf.tc[47]}}, cf.tc[47:32]};
      s1_p  <= in_beat.raw_pressure;
      // stage 2: products
      s2_a  <= $signed(s1_x * s1_t2) >>> 11;
      s2_dd <= $signed(s1_d * s1_d) >>> 12;
      s2_t3 <= s1_t3;
      s2_p  <= s1_p;
      // stage 3
      s3_a <= s2_a;
      s3_b <= $signed(s2_dd * s2_t3) >>> 14;
      s3_p <= s2_p;
      // stage 4: fine temperature
      s4_fine <= s3_fine;
      s4_v1   <= {s3_fine[31], s3_fine} - 33'd128000;
      s4_p    <= s3_p;
      // stage 5: first-level products
      s5_fine <= s4_fine;
      s5_sq   <= 64'($signed(s4_v1)) * 64'($signed(s4_v1));
      s5_v1p5 <= 64'($signed(s4_v1)) * 64'($signed(cf.pb[31:16]));
      s5_v1p2 <= 64'($signed(s4_v1)) * 64'($signed(cf.pa[31:16]));
      s5_p    <= s4_p;
      // stage 6: v2 and pre-shift v1
      s6_temp <= $signed(fine5) >>> 8;
      s6_v2   <= s5_sq6 + (s5_v1p5 << 17) + (ptc_pkg::sx16(cf.pb[15:0]) << 35);
      s6_v1a  <= s5_sq3;
      s6_n0   <= s5_v1p2 << 12;
      s6_p    <= s5_p;
      // stage 7: numerator and denominator
      s7_temp <= s6_temp;
      s7_num  <= (((64'd1048576 - {44'd0, s6_p}) << 31) - s6_v2) * 64'd3125;
      s7_den  <= $signed(((64'd1 << 47) + v1b + s6_n0) * p1) >>> 33;
    end
  end

  assign out_valid = vld[6];
  assign temp      = s7_temp;
  assign num       = s7_num;
  assign den       = s7_den;
endmodule

// ----- rtl/ptc_back.sv -----
// Back stages: pressure correction after the divide.
module ptc_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [63:0]         p,
  input  logic [31:0]         temp,
  input  logic                dz,
  input  ptc_pkg::coeffs_t    cf,
  output logic                out_valid,
  output ptc_pkg::out_beat_t  out_beat
);
  logic [4:0]  vld;
  logic [63:0] a_p, a_ps, b_p, b_ps, b_t9, b_w2, c_p, c_ll, c_w2, d_p, d_w1, d_w2;
  logic [31:0] c_x;
  logic [31:0] a_t, b_t, c_t, d_t;
  logic        a_z, b_z, c_z, d_z;
  logic [63:0] sum, sh8, pfull;

  assign sum   = d_p + d_w1 + d_w2;
  assign sh8   = $signed(sum) >>> 8;
  assign pfull = sh8 + (ptc_pkg::sx16(cf.pc[15:0]) << 4);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_p  <= p;
      a_ps <= $signed(p) >>> 13;
      a_t  <= temp;
      a_z  <= dz;
      // p9*ps, p8*p
      b_p  <= a_p;
      b_ps <= a_ps;
      b_t9 <= 64'($signed(cf.pc[47:32])) * a_ps;
      b_w2 <= $signed(64'($signed(cf.pc[31:16])) * a_p) >>> 19;
      b_t  <= a_t;
      b_z  <= a_z;
      // low 64 bits of p9*ps*ps from 32-bit partial products
      c_p  <= b_p;
      c_ll <= {32'd0, b_t9[31:0]} * {32'd0, b_ps[31:0]};
      c_x  <= b_t9[31:0] * b_ps[63:32] + b_t9[63:32] * b_ps[31:0];
      c_w2 <= b_w2;
      c_t  <= b_t;
      c_z  <= b_z;
      d_p  <= c_p;
      d_w1 <= $signed(c_ll + {c_x, 32'd0}) >>> 25;
      d_w2 <= c_w2;
      d_t  <= c_t;
      d_z  <= c_z;
      out_beat.temperature    <= d_t;
      out_beat.divide_by_zero <= d_z;
      out_beat.pressure       <= d_z ? 32'd0 : pfull[31:0];
    end
  end

  assign out_valid = vld[4];
endmodule

// ----- rtl/pressure_temp_compensation_unit.sv -----
// Pressure/temperature compensation, 64-bit integer datapath.
// Input channel: in_valid/in_ready with in_beat {raw_temperature, raw_pressure}.
// Output channel: out_valid/out_ready with out_beat {temperature, pressure,
// divide_by_zero}. Calibration: cfg_we/cfg_index/cfg_data, four 48-bit
// registers; write them only while idle, which the block does not enforce.
// Throughput: one beat per cycle when not stalled. Stages: 7 front stages, a
// 65-stage one-bit-per-stage divider and 5 correction stages.
// The whole pipe advances together; when out_ready is low and the output
// holds a beat, the pipe freezes and in_ready drops. Nothing is dropped.
// Reset clears all valid bits and calibration registers; no clearing pass.
// A zero divisor gives pressure 0 and divide_by_zero 1.
module pressure_temp_compensation_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ptc_pkg::in_beat_t   in_beat,
  output logic                out_valid,
  input  logic                out_ready,
  output ptc_pkg::out_beat_t  out_beat,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [47:0]         cfg_data
);
  ptc_pkg::coeffs_t cf;
  logic en;
  logic f_valid, d_valid;
  logic [31:0] f_temp;
  logic [63:0] f_num, f_den, d_quo;
  logic [32:0] d_side;

  // calibration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cf <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ptc_pkg::REG_TEMP:    cf.tc <= cfg_data;
        ptc_pkg::REG_PRESS_A: cf.pa <= cfg_data;
        ptc_pkg::REG_PRESS_B: cf.pb <= cfg_data;
        ptc_pkg::REG_PRESS_C: cf.pc <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en       = ~out_valid | out_ready;
  assign in_ready = en;

  ptc_front u_front (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_valid & in_ready),
    .in_beat(in_beat), .cf(cf), .out_valid(f_valid), .temp(f_temp),
    .num(f_num), .den(f_den)
  );

  ptc_divider #(.SideW(33)) u_div (
    .clk(clk), .rst(rst), .en(en), .in_valid(f_valid),
    .num(f_num), .den(f_den), .side_in({f_temp, f_den == 64'd0}),
    .out_valid(d_valid), .quo(d_quo), .side_out(d_side)
  );

  ptc_back u_back (
    .clk(clk), .rst(rst), .en(en), .in_valid(d_valid), .p(d_quo),
    .temp(d_side[32:1]), .dz(d_side[0]), .cf(cf),
    .out_valid(out_valid), .out_beat(out_beat)
  );

`ifndef SYNTH
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_beat))
    else $error("output beat changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while pipe frozen");
  a_dz: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_beat.divide_by_zero |-> out_beat.pressure == 32'd0)
    else $error("nonzero pressure on zero divisor");
`endif
endmodule

// ----- sim/pressure_temp_compensation_unit_tb.sv -----
module pressure_temp_compensation_unit_tb;

  localparam int LATENCY   = 77;
  localparam int MAX_CYCLES = 2000000;

  // Calibration set and expected output readings
  class comp_scoreboard;
    logic [47:0] coef [4];
    ptc_pkg::out_beat_t pending_readings [$];
    int          errors;

    function new();
      foreach (coef[i]) coef[i] = '0;
      errors = 0;
    endfunction

    function logic [63:0] sfld(logic [47:0] r, int pos);
      logic [15:0] v;
      v = r[pos +: 16];
      return {{48{v[15]}}, v};
    endfunction

    // Integer compensation of one raw sample pair
    function ptc_pkg::out_beat_t compensate(ptc_pkg::in_beat_t b);
      ptc_pkg::out_beat_t r;
      logic signed [31:0] t1, t2, t3, a, d, bt, fine;
      logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic signed [63:0] v1, v2, p, ps, w1, w2;
      t1 = {16'd0, coef[ptc_pkg::REG_TEMP][15:0]};
      t2 = 32'(signed'(coef[ptc_pkg::REG_TEMP][31:16]));
      t3 = 32'(signed'(coef[ptc_pkg::REG_TEMP][47:32]));
      a = ((signed'({15'd0, b.raw_temperature[19:3]})) - (t1 <<< 1)) * t2;
      a = a >>> 11;
      d = signed'({16'd0, b.raw_temperature[19:4]}) - t1;
      bt = ((((d * d) >>> 12) * t3) >>> 14);
      fine = a + bt;
      r.temperature = (fine * 5 + 128) >>> 8;
      p1 = {48'd0, coef[ptc_pkg::REG_PRESS_A][15:0]};
      p2 = sfld(coef[ptc_pkg::REG_PRESS_A], 16);
      p3 = sfld(coef[ptc_pkg::REG_PRESS_A], 32);
      p4 = sfld(coef[ptc_pkg::REG_PRESS_B], 0);
      p5 = sfld(coef[ptc_pkg::REG_PRESS_B], 16);
      p6 = sfld(coef[ptc_pkg::REG_PRESS_B], 32);
      p7 = sfld(coef[ptc_pkg::REG_PRESS_C], 0);
      p8 = sfld(coef[ptc_pkg::REG_PRESS_C], 16);
      p9 = sfld(coef[ptc_pkg::REG_PRESS_C], 32);
      v1 = 64'(fine) - 64'sd128000;
      v2 = v1 * v1 * p6;
      v2 = v2 + ((v1 * p5) <<< 17);
      v2 = v2 + (p4 <<< 35);
      v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
      v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
      r.pressure = '0;
      r.divide_by_zero = 1'b0;
      if (v1 == 0) begin
        r.divide_by_zero = 1'b1;
      end else begin
        p = 64'sd1048576 - signed'({44'd0, b.raw_pressure});
        p = ((p <<< 31) - v2) * 64'sd3125;
        // most negative / -1 wraps
        if (p == {1'b1, 63'd0} && v1 == -64'sd1) p = p;
        else p = p / v1;
        ps = p >>> 13;
        w1 = (p9 * ps * ps) >>> 25;
        w2 = (p8 * p) >>> 19;
        p = ((p + w1 + w2) >>> 8) + (p7 <<< 4);
        r.pressure = p[31:0];
      end
      return r;
    endfunction

    function void note_sample(ptc_pkg::in_beat_t b);
      pending_readings.push_back(compensate(b));
    endfunction

    function void check_reading(ptc_pkg::out_beat_t got);
      ptc_pkg::out_beat_t exp_r;
      if (pending_readings.size() == 0) begin
        $display("%0t: unexpected beat %h", $time, got);
        errors++;
        return;
      end
      exp_r = pending_readings.pop_front();
      if (got.temperature !== exp_r.temperature) begin
        $display("%0t: temperature exp %0d got %0d", $time, exp_r.temperature,
                 got.temperature);
        errors++;
      end
      if (got.pressure !== exp_r.pressure) begin
        $display("%0t: pressure exp %h got %h", $time, exp_r.pressure, got.pressure);
        errors++;
      end
      if (got.divide_by_zero !== exp_r.divide_by_zero) begin
        $display("%0t: divide_by_zero exp %b got %b", $time, exp_r.divide_by_zero,
                 got.divide_by_zero);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  ptc_pkg::in_beat_t  in_beat;
  ptc_pkg::out_beat_t out_beat;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [47:0] cfg_data;
  comp_scoreboard sb;
  int cycles = 0;
  bit hold_mode = 0;

  pressure_temp_compensation_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_beat(in_beat),
    .out_valid(out_valid), .out_ready(out_ready), .out_beat(out_beat),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Beat monitor and cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && in_valid && in_ready) sb.note_sample(in_beat);
    if (!rst && out_valid && out_ready) sb.check_reading(out_beat);
    if (cycles > MAX_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Receiver: random stalls, one long hold-off on request
  initial begin
    int g;
    bit held;
    held = 0;
    out_ready = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_mode && !held) begin
        held = 1;
        out_ready <= 0;
        repeat (300) @(negedge clk);
      end
      g = gap_len();
      if (g == 0) begin
        out_ready <= 1;
        @(negedge clk);
      end else begin
        out_ready <= 0;
        repeat (g) @(negedge clk);
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [47:0] val);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 0;
    sb.coef[idx] = val;
  endtask

  task automatic send_sample(logic [19:0] rt, logic [19:0] rp, bit gaps);
    int g;
    if (gaps) begin
      g = gap_len();
      if (g > 0) begin
        in_valid <= 0;
        repeat (g) @(negedge clk);
      end
    end
    in_valid <= 1;
    in_beat <= '{raw_temperature: rt, raw_pressure: rp};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending_readings.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  function automatic logic [47:0] rand_cal();
    return {16'($urandom), 16'($urandom), 16'($urandom)};
  endfunction

  // Realistic datasheet-like calibration, small random jitter
  task automatic load_typical();
    write_reg(ptc_pkg::REG_TEMP, {16'd50, 16'd26435, 16'd27504});
    write_reg(ptc_pkg::REG_PRESS_A,
              {16'hD0D0 ^ 16'($urandom_range(0, 15)), 16'hD690, 16'd36477});
    write_reg(ptc_pkg::REG_PRESS_B, {16'hFFF9, 16'd140, 16'd2855});
    write_reg(ptc_pkg::REG_PRESS_C,
              {16'hCFB8 ^ 16'($urandom_range(0, 7)), 16'hD4E8, 16'd15500});
  endtask

  initial begin
    int n;
    sb = new();
    rst = 1;
    in_valid = 0;
    in_beat = '0;
    cfg_we = 0;
    cfg_index = ptc_pkg::REG_TEMP;
    cfg_data = '0;
    repeat (2) @(negedge clk);
    rst = 0;

    // Reset calibration: divisor zero
    send_sample(20'd0, 20'd0, 0);
    send_sample(20'hFFFFF, 20'hFFFFF, 0);
    drain();

    // Directed extremes
    load_typical();
    send_sample(20'd0, 20'd0, 0);
    send_sample(20'hFFFFF, 20'd0, 0);
    send_sample(20'd0, 20'hFFFFF, 0);
    send_sample(20'hFFFFF, 20'hFFFFF, 0);
    send_sample(20'd519888, 20'd415148, 0);
    send_sample(20'h55555, 20'hAAAAA, 0);
    send_sample(20'hAAAAA, 20'h55555, 0);
    drain();
    write_reg(ptc_pkg::REG_TEMP, 48'hFFFF_FFFF_FFFF);
    write_reg(ptc_pkg::REG_PRESS_A, 48'hFFFF_FFFF_FFFF);
    write_reg(ptc_pkg::REG_PRESS_B, 48'hFFFF_FFFF_FFFF);
    write_reg(ptc_pkg::REG_PRESS_C, 48'hFFFF_FFFF_FFFF);
    send_sample(20'd0, 20'hFFFFF, 0);
    send_sample(20'hFFFFF, 20'd0, 0);
    send_sample(20'd12345, 20'd54321, 0);
    drain();
    write_reg(ptc_pkg::REG_TEMP, 48'h8000_8000_8000);
    write_reg(ptc_pkg::REG_PRESS_A, 48'h8000_8000_0001);
    write_reg(ptc_pkg::REG_PRESS_B, 48'h7FFF_7FFF_7FFF);
    write_reg(ptc_pkg::REG_PRESS_C, 48'h8000_7FFF_8000);
    send_sample(20'd0, 20'd0, 0);
    send_sample(20'hFFFFF, 20'hFFFFF, 0);
    drain();

    // Random phases: mostly typical calibration, some arbitrary
    for (int ph = 0; ph < 12; ph++) begin
      if (ph % 3 == 2) begin
        for (int i = 0; i < 4; i++) write_reg(2'(i), rand_cal());
      end else begin
        load_typical();
      end
      n = 0;
      while (n < 128) begin
        if (ph == 4 && n == 20) hold_mode = 1;
        send_sample(ph % 3 == 0 ? 20'($urandom_range(400000, 600000)) : 20'($urandom),
                    20'($urandom), 1);
        n++;
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending_readings.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
